@@ sv/bmg_pkg.sv @@
// Package for the Box-Muller Gaussian sample generator.
// Holds the word types, stage map, arithmetic constants and CORDIC table.
// No dependencies.
package bmg_pkg;

  // Input word: two uniform fractions x/2^32
  typedef struct packed {
    logic [31:0] uniform_a;
    logic [31:0] uniform_b;
  } bmg_in_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] sample_q16;
    logic               rejected;
    logic               saturated;
  } bmg_out_t;

  // Configuration register indexes
  localparam logic REG_MEAN = 1'b0;
  localparam logic REG_STD  = 1'b1;

  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int CORDIC_ROUNDS = 24;
  localparam int LOG_FRAC_BITS = 24;
  localparam int SQRT_STEPS    = 19;
  localparam int S_W           = 38;   // width of -2 ln(u) in Q32
  localparam int CW            = 34;   // CORDIC datapath width

  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032875;

  // Stage map
  localparam int ST_LN   = LOG_FRAC_BITS + 1;       // log scale by 2 ln 2
  localparam int ST_SQ0  = ST_LN + 1;               // first square root step
  localparam int ST_RC   = ST_SQ0 + SQRT_STEPS;     // radius times cosine
  localparam int ST_ZS   = ST_RC + 1;               // times std deviation
  localparam int ST_OUT  = ST_ZS + 1;               // add mean, saturate
  localparam int NSTG    = ST_OUT + 1;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_ROUNDS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670675,   32'd1335343,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

@@ sv/bmg_ctrl.sv @@
// Pipeline control: valid bit per stage and per-stage load enables.
// Bubbles collapse, so a stalled output does not hold up empty stages.
// Depends on bmg_pkg.
module bmg_ctrl import bmg_pkg::*; #(
  parameter int N = NSTG
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         out_ready,
  output logic [N-1:0] en,
  output logic         last_valid
);

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[N-1] = !v_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < N; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign last_valid = v_r[N-1];

endmodule

@@ sv/bmg_log.sv @@
// -2 ln(u) in Q32: leading-one normalize, 24 squaring stages for the
// log2 fraction bits, then scale by 2 ln 2. Depends on bmg_pkg.
module bmg_log import bmg_pkg::*; (
  input  logic            clk,
  input  logic [NSTG-1:0] en,
  input  logic [31:0]     a,
  output logic [S_W-1:0]  s
);

  logic [31:0] m_r [LOG_FRAC_BITS+1];
  logic [5:0]  e_r [LOG_FRAC_BITS+1];
  logic [LOG_FRAC_BITS-1:0] f_r [LOG_FRAC_BITS+1];
  logic [S_W-1:0] s_r;

  logic [4:0] p;

  // leading one position
  always_comb begin
    p = 5'd0;
    for (int j = 0; j < 32; j++) begin
      if (a[j]) p = j[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r[0] <= a << (5'd31 - p);
      e_r[0] <= 6'd32 - {1'b0, p};
      f_r[0] <= '0;
    end
  end

  // one fraction bit per squaring stage
  for (genvar k = 1; k <= LOG_FRAC_BITS; k++) begin : g_sq
    logic [63:0] prod;
    logic [32:0] t;
    assign prod = m_r[k-1] * m_r[k-1];
    assign t    = prod[63:31];
    always_ff @(posedge clk) begin
      if (en[k]) begin
        m_r[k] <= t[32] ? t[32:1] : t[31:0];
        f_r[k] <= {f_r[k-1][LOG_FRAC_BITS-2:0], t[32]};
        e_r[k] <= e_r[k-1];
      end
    end
  end

  // L = -log2(u) in Q24, times 2 ln 2
  logic [29:0] l_val;
  logic [60:0] lprod;
  assign l_val = {e_r[LOG_FRAC_BITS][4:0], 25'd0} == 30'd0 && e_r[LOG_FRAC_BITS][5]
               ? {e_r[LOG_FRAC_BITS][5:0], 24'd0} - {6'd0, f_r[LOG_FRAC_BITS]}
               : {e_r[LOG_FRAC_BITS][5:0], 24'd0} - {6'd0, f_r[LOG_FRAC_BITS]};
  assign lprod = l_val * TWO_LN2_Q30;

  always_ff @(posedge clk) begin
    if (en[ST_LN]) begin
      s_r <= lprod[59:22];
    end
  end

  assign s = s_r;

endmodule

@@ sv/bmg_sqrt.sv @@
// Integer square root, one result bit per stage (19 stages).
// Depends on bmg_pkg.
module bmg_sqrt import bmg_pkg::*; (
  input  logic            clk,
  input  logic [NSTG-1:0] en,
  input  logic [S_W-1:0]  s,
  output logic [18:0]     r
);

  logic [S_W-1:0] v_r   [SQRT_STEPS];
  logic [S_W-1:0] res_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [S_W-1:0] BIT = S_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [S_W-1:0] v_in;
    logic [S_W-1:0] res_in;
    logic [S_W:0]   trial;
    if (k == 0) begin : g_first
      assign v_in   = s;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign res_in = res_r[k-1];
    end
    assign trial = {1'b0, res_in} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en[ST_SQ0+k]) begin
        if ({1'b0, v_in} >= trial) begin
          v_r[k]   <= v_in - trial[S_W-1:0];
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          v_r[k]   <= v_in;
          res_r[k] <= res_in >> 1;
        end
      end
    end
  end

  assign r = res_r[SQRT_STEPS-1][18:0];

endmodule

@@ sv/bmg_cordic.sv @@
// Cosine of the quantized angle: half-turn fold, then 24 CORDIC rotation
// stages. Returns x and the fold sign. Depends on bmg_pkg.
module bmg_cordic import bmg_pkg::*; #(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic [NSTG-1:0]       en,
  input  logic [31:0]           b,
  output logic signed [CW-1:0]  x,
  output logic                  neg
);

  localparam int DROP = 32 - (TABLE_ADDR_BITS + 2);
  localparam logic [31:0] MASK = ~((32'd1 << DROP) - 32'd1);

  logic signed [CW-1:0] x_r [CORDIC_ROUNDS+1];
  logic signed [CW-1:0] y_r [CORDIC_ROUNDS+1];
  logic signed [CW-1:0] z_r [CORDIC_ROUNDS+1];
  logic                 n_r [CORDIC_ROUNDS+1];

  logic [31:0] ang_q;
  logic [31:0] ang_sum;
  logic        fold;
  logic [31:0] ang_f;

  // quantize and fold into [-90, 90) degrees
  assign ang_q   = b & MASK;
  assign ang_sum = ang_q + 32'h4000_0000;
  assign fold    = ang_sum[31];
  assign ang_f   = fold ? ang_q - 32'h8000_0000 : ang_q;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0] <= CORDIC_X0;
      y_r[0] <= '0;
      z_r[0] <= CW'($signed(ang_f));
      n_r[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_ROUNDS; i++) begin : g_rot
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = $signed({{(CW-32){1'b0}}, ATAN_TURNS[i]});
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end
        n_r[i+1] <= n_r[i];
      end
    end
  end

  assign x   = x_r[CORDIC_ROUNDS];
  assign neg = n_r[CORDIC_ROUNDS];

endmodule

@@ sv/box_muller_gaussian_sample_top.sv @@
// Top level of the Box-Muller Gaussian sample generator.
// Depends on bmg_pkg, bmg_ctrl, bmg_log, bmg_sqrt, bmg_cordic.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data    | word of two uniform fractions
//  result  | out_valid, out_ready, out_data | word: sample, rejected, saturated
//  config  | cfg_we, cfg_index, cfg_wdata   | register write, no wait
//
// Stages: 1 normalize, 24 log squaring, 1 log scale, 19 square root,
// 3 multiply/add; one word enters per cycle while in_ready is high.
// Each stage has a valid bit; an empty stage loads even while later stages
// stall, so in_ready stays high while a result waits as long as a bubble exists.
// Synchronous active-low reset clears valid bits, sets mean to 0 and std to 65536.
module box_muller_gaussian_sample_top import bmg_pkg::*; #(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bmg_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output bmg_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [NSTG-1:0] en;
  logic signed [31:0] mean_r;
  logic [31:0]        std_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= 32'sd0;
      std_r  <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MEAN: mean_r <= $signed(cfg_wdata);
        REG_STD:  std_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  bmg_ctrl #(.N(NSTG)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .out_ready  (out_ready),
    .en         (en),
    .last_valid (out_valid)
  );

  assign in_ready = en[0];

  logic [S_W-1:0] s;
  logic [18:0]    r;
  logic signed [CW-1:0] cx;
  logic                 cneg;

  bmg_log u_log (
    .clk (clk),
    .en  (en),
    .a   (in_data.uniform_a),
    .s   (s)
  );

  bmg_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .s   (s),
    .r   (r)
  );

  bmg_cordic #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_cordic (
    .clk (clk),
    .en  (en),
    .b   (in_data.uniform_b),
    .x   (cx),
    .neg (cneg)
  );

  // reject flag travels alongside the whole pipe
  logic rej_r [ST_ZS+1];
  always_ff @(posedge clk) begin
    if (en[0]) rej_r[0] <= (in_data.uniform_a == 32'd0) || (in_data.uniform_b == 32'd0);
  end
  for (genvar k = 1; k <= ST_ZS; k++) begin : g_rej
    always_ff @(posedge clk) begin
      if (en[k]) rej_r[k] <= rej_r[k-1];
    end
  end

  // cosine waits for the radius; fold sign applied on entry
  localparam int CD = ST_RC - (CORDIC_ROUNDS + 1);
  logic signed [CW-1:0] c_r [CD];
  always_ff @(posedge clk) begin
    if (en[CORDIC_ROUNDS+1]) c_r[0] <= cneg ? -cx : cx;
  end
  for (genvar k = 1; k < CD; k++) begin : g_cd
    always_ff @(posedge clk) begin
      if (en[CORDIC_ROUNDS+1+k]) c_r[k] <= c_r[k-1];
    end
  end

  // z = (r * c) >> 30
  logic signed [53:0] rc_prod;
  logic signed [23:0] z_r;
  assign rc_prod = $signed({1'b0, r}) * c_r[CD-1];
  always_ff @(posedge clk) begin
    if (en[ST_RC]) z_r <= rc_prod[53:30];
  end

  // z * std deviation
  logic signed [56:0] zs_r;
  always_ff @(posedge clk) begin
    if (en[ST_ZS]) zs_r <= z_r * $signed({1'b0, std_r});
  end

  // add mean and saturate
  logic signed [41:0] sum;
  logic               over;
  assign sum  = {zs_r[56], zs_r[56:16]} + {{10{mean_r[31]}}, mean_r};
  assign over = (sum[41:31] != {11{sum[41]}});

  bmg_out_t out_r;
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (rej_r[ST_ZS]) begin
        out_r.sample_q16 <= 32'sd0;
        out_r.rejected   <= 1'b1;
        out_r.saturated  <= 1'b0;
      end else begin
        out_r.sample_q16 <= over ? (sum[41] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum[31:0];
        out_r.rejected   <= 1'b0;
        out_r.saturated  <= over;
      end
    end
  end

  assign out_data = out_r;

endmodule
